/* rtl/pcgr_pkg.sv */
// Package for the PCG32 range generator: constants, queue entry type,
// control structs, back-end state type and the XSH-RR output function.
// No dependencies.
`default_nettype none

package pcgr_pkg;

   localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;
   localparam int unsigned XS_SHIFT_A = 18;
   localparam int unsigned XS_SHIFT_B = 27;
   localparam int unsigned ROT_SHIFT  = 59;

   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 64;
   localparam logic [CSR_AW-1:0] SEED_ADDR = CSR_AW'(0);

   localparam int unsigned QUEUE_AW    = 1;
   localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam int unsigned DIV_BITS = 32;
   localparam int unsigned DIV_CW   = $clog2(DIV_BITS);

   typedef struct packed {
      logic signed [31:0] min_value;
      logic [31:0]        span;
      logic               err;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic        load;
      logic [63:0] seed;
   } seed_load_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   function automatic logic [31:0] pcg_output(input logic [63:0] old);
      logic [31:0] xs;
      logic [4:0]  rot;
      begin
         xs  = 32'(((old >> XS_SHIFT_A) ^ old) >> XS_SHIFT_B);
         rot = old[63:ROT_SHIFT];
         return (xs >> rot) | (xs << 5'(5'd0 - rot));
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/pcgr_if.sv */
// Valid/ready channel interfaces for range requests and results.
// No dependencies.
`default_nettype none

interface pcgr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] min_value;
   logic signed [31:0] max_value;

   modport source (output valid, output min_value, output max_value, input ready);
   modport sink (input valid, input min_value, input max_value, output ready);
endinterface

interface pcgr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               range_error;

   modport source (output valid, output value, output range_error, input ready);
   modport sink (input valid, input value, input range_error, output ready);
endinterface

`default_nettype wire

/* rtl/pcgr_front.sv */
// Front end: accepts range requests, flags empty or inverted ranges and computes the span.
// Depends on pcgr_pkg and pcgr_req_if.
`default_nettype none

module pcgr_front
   import pcgr_pkg::*;
(
   pcgr_req_if.sink       req,
   input  queue_stat_type q_stat,
   output logic           push,
   output item_type       push_item
);

   assign req.ready = !q_stat.full;
   assign push      = req.valid && !q_stat.full;

   always_comb begin
      push_item.min_value = req.min_value;
      push_item.span      = $unsigned(req.max_value) - $unsigned(req.min_value);
      push_item.err       = (req.min_value >= req.max_value);
   end

endmodule

`default_nettype wire

/* rtl/pcgr_fifo.sv */
// Short queue of classified items between front and back end.
// Depends on pcgr_pkg.
`default_nettype none

module pcgr_fifo
   import pcgr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  item_type       push_item,
   input  logic           pop,
   output item_type       pop_item,
   output queue_stat_type stat
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_item   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/pcgr_back.sv */
// Back end: LCG state with a shared 32x32 multiplier, radix-2 remainder
// unit and the result register. Depends on pcgr_pkg and pcgr_rsp_if.
`default_nettype none

module pcgr_back
   import pcgr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seed_load_type  seed_ld,
   input  queue_stat_type q_stat,
   input  item_type       q_item,
   output logic           pop,
   pcgr_rsp_if.source     rsp
);

   back_state_type     state_ff, state_in;

   logic [63:0]        gen_state_ff, gen_state_in;
   logic [63:0]        lcg_src_ff;
   logic [1:0]         lcg_ph_ff;
   logic               lcg_busy_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        cross_ff;
   logic               lcg_start;
   logic [63:0]        lcg_start_src;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   logic [31:0]        dvd_ff, rem_ff, span_ff;
   logic signed [31:0] min_ff;
   logic [DIV_CW-1:0]  cnt_ff;
   logic [32:0]        trial, diff;
   logic [31:0]        rem_in;

   logic               out_valid_ff;
   logic signed [31:0] value_ff;
   logic               err_ff;
   logic               slot_free;
   logic               launch, out_load, out_err;
   logic signed [31:0] out_value;

   assign slot_free       = !out_valid_ff || rsp.ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.value       = value_ff;
   assign rsp.range_error = err_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty && !lcg_busy_ff && !q_item.err) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (cnt_ff == DIV_CW'(DIV_BITS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      launch    = 1'b0;
      out_load  = 1'b0;
      out_err   = 1'b0;
      out_value = '1;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty && !lcg_busy_ff) begin
               if (q_item.err) begin
                  pop      = slot_free;
                  out_load = slot_free;
                  out_err  = 1'b1;
               end else begin
                  pop    = 1'b1;
                  launch = 1'b1;
               end
            end
         end
         BK_DIV: begin
         end
         BK_DONE: begin
            out_load  = slot_free;
            out_value = $signed(32'($unsigned(min_ff) + rem_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // LCG step: s*M + INC over three products and a final add
   assign lcg_start     = seed_ld.load || launch;
   assign lcg_start_src = seed_ld.load ? seed_ld.seed : gen_state_ff;
   assign mul_a         = (lcg_ph_ff == 2'd2) ? lcg_src_ff[63:32] : lcg_src_ff[31:0];
   assign mul_b         = (lcg_ph_ff == 2'd1) ? LCG_MULT[63:32] : LCG_MULT[31:0];
   assign mul_p         = mul_a * mul_b;
   assign gen_state_in  = prod_ff + {cross_ff, 32'd0} + LCG_INC;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_busy_ff  <= 1'b0;
         lcg_ph_ff    <= 2'd0;
         gen_state_ff <= LCG_INC;
      end else if (lcg_start) begin
         lcg_busy_ff <= 1'b1;
         lcg_ph_ff   <= 2'd0;
      end else if (lcg_busy_ff) begin
         lcg_ph_ff <= lcg_ph_ff + 2'd1;
         if (lcg_ph_ff == 2'd3) begin
            lcg_busy_ff  <= 1'b0;
            gen_state_ff <= gen_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lcg_start) begin
         lcg_src_ff <= lcg_start_src;
      end
      unique case (lcg_ph_ff)
         2'd0: prod_ff <= mul_p;
         2'd1: cross_ff <= mul_p[31:0];
         2'd2: cross_ff <= cross_ff + mul_p[31:0];
         default: begin
         end
      endcase
   end

   // restoring remainder, one dividend bit a cycle
   assign trial  = {rem_ff, dvd_ff[31]};
   assign diff   = trial - {1'b0, span_ff};
   assign rem_in = diff[32] ? trial[31:0] : diff[31:0];

   always_ff @(posedge clock) begin
      if (launch) begin
         dvd_ff  <= pcg_output(gen_state_ff);
         rem_ff  <= '0;
         span_ff <= q_item.span;
         min_ff  <= q_item.min_value;
         cnt_ff  <= '0;
      end else if (state_ff == BK_DIV) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         value_ff <= out_value;
         err_ff   <= out_err;
      end
   end

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      lcg_start |-> !lcg_busy_ff)
      else $error("LCG restarted while busy");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(lcg_busy_ff && lcg_ph_ff == 2'd3) |=> $stable(gen_state_ff))
      else $error("generator state changed outside an LCG step");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      launch |=> (state_ff == BK_DIV) && (cnt_ff == '0) && lcg_busy_ff)
      else $error("divider not started with the LCG step");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && slot_free) |=> out_valid_ff && !err_ff)
      else $error("range result not loaded");
`endif

endmodule

`default_nettype wire

/* rtl/pcg32_range_generator_top.sv */
// Top level of the PCG32 XSH-RR range generator: seed register port,
// front end, item queue and back end. Depends on pcgr_pkg and pcgr_if.
//
// Use: send {min_value, max_value} items on req_ch; each yields one item on
// rsp_ch in order. A valid range gives min + raw % (max - min); an empty or
// inverted range gives -1 with range_error set and leaves the state alone.
// A valid range goes from acceptance to rsp_ch valid through a launch step,
// a remainder iteration per dividend bit and a result load; the remainder
// unit works one bit per cycle and takes one item at a time, launching the
// next only after the last result is loaded. Error items are answered from
// the idle state when the back end is free. The 64-bit LCG step runs on a
// shared 32x32 multiplier, in the shadow of the remainder iterations.
// A two-entry queue decouples the request side; req_ch.ready drops when full.
// If rsp_ch stalls, the result waits in its register while the next item is
// already being computed; computation then holds until the register frees.
// Reset: state = seed 0 advanced once, seed register 0, queue empty.
// Writing the seed (address 0) reloads the state with the seed advanced
// once; write only while the block is idle.
`default_nettype none

module pcg32_range_generator_top
   import pcgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   pcgr_req_if.sink          req_ch,
   pcgr_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [63:0]    seed_ff;
   logic           seed_wr;
   seed_load_type  seed_ld;
   queue_stat_type q_stat;
   logic           push, pop;
   item_type       push_item, pop_item;

   assign pready  = 1'b1;
   assign seed_wr = psel && penable && pwrite && (paddr == SEED_ADDR);
   assign prdata  = (paddr == SEED_ADDR) ? seed_ff : '0;

   always_comb begin
      seed_ld.load = seed_wr;
      seed_ld.seed = pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (seed_wr) begin
         seed_ff <= pwdata;
      end
   end

   pcgr_front u_front (
      .req       (req_ch),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   pcgr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   pcgr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .seed_ld (seed_ld),
      .q_stat  (q_stat),
      .q_item  (pop_item),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire
